>>> hdl/cabs_pkg.sv
// ----------------------------------------------------------------------------
// cabs_pkg: shared definitions for the class aware box suppression block
// Holds the default parameter values, field widths, the controller states,
// the datapath operation codes and the command and status structs.
// ----------------------------------------------------------------------------
package cabs_pkg;

   localparam int MAX_DETS_DEF   = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int SCORE_BITS_DEF = 16;
   localparam int CLASS_BITS     = 8;
   localparam int BATCH_BITS     = 4;
   localparam int THR_BITS       = 16;

   localparam logic [THR_BITS-1:0] THR_RESET = 16'd29491;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_PIV,
      ST_SORT_CMP,
      ST_SORT_WAIT,
      ST_SUP_INIT,
      ST_SUP_PIV,
      ST_SUP_CMP,
      ST_SUP_DRAIN,
      ST_EMIT_SCAN,
      ST_EMIT_WAIT,
      ST_EMIT_NONE,
      ST_CLEAR
   } state_type;

   typedef enum logic [2:0] {
      OP_SORT_PIV,
      OP_SORT_CMP,
      OP_SUP_PIV,
      OP_SUP_CMP,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic   load_en;
      logic   issue;
      op_type op;
      logic   order_write;
      logic   keep_init;
      logic   emit_none;
      logic   set_clear;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic keep_bit;
      logic out_free;
      logic none_kept;
      logic last_seen;
   } status_type;

endpackage

>>> hdl/cabs_channels.sv
// ----------------------------------------------------------------------------
// cabs_channels: valid/ready channels of the box suppression block
// The request channel carries one detection word, the response channel one
// kept box word with its set information.
// ----------------------------------------------------------------------------
interface cabs_req_if #(
   parameter int COORD_BITS = cabs_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabs_pkg::SCORE_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic [COORD_BITS-1:0]           center_x;
   logic [COORD_BITS-1:0]           center_y;
   logic [COORD_BITS-1:0]           box_width;
   logic [COORD_BITS-1:0]           box_height;
   logic [SCORE_BITS-1:0]           score;
   logic [cabs_pkg::CLASS_BITS-1:0] class_id;
   logic [cabs_pkg::BATCH_BITS-1:0] batch_index;
   logic                            last;

   modport source (output valid, center_x, center_y, box_width, box_height, score,
                   class_id, batch_index, last, input ready);
   modport sink (input valid, center_x, center_y, box_width, box_height, score,
                 class_id, batch_index, last, output ready);
endinterface

interface cabs_rsp_if #(
   parameter int COORD_BITS = cabs_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabs_pkg::SCORE_BITS_DEF,
   parameter int COUNT_BITS = 7
);
   logic                            valid;
   logic                            ready;
   logic [COORD_BITS-1:0]           out_center_x;
   logic [COORD_BITS-1:0]           out_center_y;
   logic [COORD_BITS-1:0]           out_width;
   logic [COORD_BITS-1:0]           out_height;
   logic [SCORE_BITS-1:0]           out_score;
   logic [cabs_pkg::CLASS_BITS-1:0] out_class;
   logic [cabs_pkg::BATCH_BITS-1:0] out_batch;
   logic [COUNT_BITS-1:0]           kept_count;
   logic                            none_kept;
   logic                            overflowed;
   logic                            end_of_set;

   modport source (output valid, out_center_x, out_center_y, out_width, out_height,
                   out_score, out_class, out_batch, kept_count, none_kept, overflowed,
                   end_of_set, input ready);
   modport sink (input valid, out_center_x, out_center_y, out_width, out_height,
                 out_score, out_class, out_batch, kept_count, none_kept, overflowed,
                 end_of_set, output ready);
endinterface

>>> hdl/cabs_ctrl.sv
// ----------------------------------------------------------------------------
// cabs_ctrl: sequencer of the box suppression block
// Steps through loading, rank sort, pairwise suppression and emission, and
// drives the datapath with one command per cycle outside its wait states.
// ----------------------------------------------------------------------------
module cabs_ctrl #(
   parameter int MAX_DETS = cabs_pkg::MAX_DETS_DEF,
   localparam int IW = $clog2(MAX_DETS),
   localparam int CW = $clog2(MAX_DETS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cabs_pkg::status_type status,
   input  logic [CW-1:0]        n,
   output cabs_pkg::cmd_type    cmd,
   output logic [IW-1:0]        idx
);

   cabs_pkg::state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] n_m1;

   assign n_m1 = n - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cabs_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd      = '{load_en: 1'b0, issue: 1'b0, op: cabs_pkg::OP_SORT_PIV,
                   order_write: 1'b0, keep_init: 1'b0, emit_none: 1'b0,
                   set_clear: 1'b0};
      idx      = i_ff[IW-1:0];
      case (state_ff)
         cabs_pkg::ST_IDLE: begin
            cmd.load_en = 1'b1;
            if (status.last_seen) begin
               i_in     = '0;
               state_in = cabs_pkg::ST_SORT_PIV;
            end
         end
         cabs_pkg::ST_SORT_PIV: begin
            if (i_ff == n) begin
               i_in     = '0;
               state_in = cabs_pkg::ST_SUP_INIT;
            end else begin
               cmd.issue = 1'b1;
               cmd.op    = cabs_pkg::OP_SORT_PIV;
               j_in      = '0;
               state_in  = cabs_pkg::ST_SORT_CMP;
            end
         end
         cabs_pkg::ST_SORT_CMP: begin
            cmd.issue = 1'b1;
            cmd.op    = cabs_pkg::OP_SORT_CMP;
            idx       = j_ff[IW-1:0];
            j_in      = j_ff + CW'(1);
            if (j_ff == n_m1) begin
               state_in = cabs_pkg::ST_SORT_WAIT;
            end
         end
         cabs_pkg::ST_SORT_WAIT: begin
            if (!status.busy) begin
               cmd.order_write = 1'b1;
               i_in            = i_ff + CW'(1);
               state_in        = cabs_pkg::ST_SORT_PIV;
            end
         end
         cabs_pkg::ST_SUP_INIT: begin
            cmd.keep_init = 1'b1;
            i_in          = '0;
            state_in      = cabs_pkg::ST_SUP_PIV;
         end
         cabs_pkg::ST_SUP_PIV: begin
            if (i_ff == n) begin
               i_in     = '0;
               state_in = status.none_kept ? cabs_pkg::ST_EMIT_NONE
                                           : cabs_pkg::ST_EMIT_SCAN;
            end else if (status.keep_bit && (i_ff != n_m1)) begin
               cmd.issue = 1'b1;
               cmd.op    = cabs_pkg::OP_SUP_PIV;
               j_in      = i_ff + CW'(1);
               state_in  = cabs_pkg::ST_SUP_CMP;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         cabs_pkg::ST_SUP_CMP: begin
            cmd.issue = 1'b1;
            cmd.op    = cabs_pkg::OP_SUP_CMP;
            idx       = j_ff[IW-1:0];
            j_in      = j_ff + CW'(1);
            if (j_ff == n_m1) begin
               state_in = cabs_pkg::ST_SUP_DRAIN;
            end
         end
         cabs_pkg::ST_SUP_DRAIN: begin
            if (!status.busy) begin
               i_in     = i_ff + CW'(1);
               state_in = cabs_pkg::ST_SUP_PIV;
            end
         end
         cabs_pkg::ST_EMIT_SCAN: begin
            if (i_ff == n) begin
               state_in = cabs_pkg::ST_CLEAR;
            end else if (status.keep_bit) begin
               if (status.out_free) begin
                  cmd.issue = 1'b1;
                  cmd.op    = cabs_pkg::OP_EMIT;
                  state_in  = cabs_pkg::ST_EMIT_WAIT;
               end
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         cabs_pkg::ST_EMIT_WAIT: begin
            if (!status.busy) begin
               i_in     = i_ff + CW'(1);
               state_in = cabs_pkg::ST_EMIT_SCAN;
            end
         end
         cabs_pkg::ST_EMIT_NONE: begin
            if (status.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = cabs_pkg::ST_CLEAR;
            end
         end
         cabs_pkg::ST_CLEAR: begin
            cmd.set_clear = 1'b1;
            state_in      = cabs_pkg::ST_IDLE;
         end
         default: begin
            state_in = cabs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/cabs_datapath.sv
// ----------------------------------------------------------------------------
// cabs_datapath: storage and arithmetic of the box suppression block
// Detection and order memories, the rank counter of the sort, the IoU
// pipeline, the keep marks and the response register.
// ----------------------------------------------------------------------------
module cabs_datapath #(
   parameter int MAX_DETS   = cabs_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = cabs_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabs_pkg::SCORE_BITS_DEF,
   localparam int IW = $clog2(MAX_DETS),
   localparam int CW = $clog2(MAX_DETS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cabs_pkg::cmd_type            cmd,
   input  logic [IW-1:0]                idx,
   output cabs_pkg::status_type         status,
   output logic [CW-1:0]                n,
   input  logic                         csr_we,
   input  logic [cabs_pkg::THR_BITS-1:0] csr_wdata,
   cabs_req_if.sink                     req_ch,
   cabs_rsp_if.source                   rsp_ch
);

   localparam int C   = COORD_BITS;
   localparam int S   = SCORE_BITS;
   localparam int DW  = C + 1;
   localparam int IN  = 2 * C + 2;
   localparam int UN  = 2 * C + 3;
   localparam int RW  = UN + cabs_pkg::THR_BITS;

   typedef struct packed {
      logic [C-1:0]                    cx;
      logic [C-1:0]                    cy;
      logic [C-1:0]                    w;
      logic [C-1:0]                    h;
      logic [S-1:0]                    score;
      logic [cabs_pkg::CLASS_BITS-1:0] cls;
      logic [cabs_pkg::BATCH_BITS-1:0] batch;
   } det_type;

   function automatic logic [DW-1:0] overlap(input logic [C-1:0] ca, input logic [C-1:0] sa,
                                             input logic [C-1:0] cb, input logic [C-1:0] sb);
      logic signed [C+2:0] alo, ahi, blo, bhi, hi, lo, d;
      alo = $signed({2'b00, ca, 1'b0}) - $signed({3'b000, sa});
      ahi = $signed({2'b00, ca, 1'b0}) + $signed({3'b000, sa});
      blo = $signed({2'b00, cb, 1'b0}) - $signed({3'b000, sb});
      bhi = $signed({2'b00, cb, 1'b0}) + $signed({3'b000, sb});
      hi  = (ahi < bhi) ? ahi : bhi;
      lo  = (alo > blo) ? alo : blo;
      d   = hi - lo;
      overlap = (!d[C+2] && (d != '0)) ? d[DW-1:0] : '0;
   endfunction

   det_type det_mem [MAX_DETS];
   logic [IW-1:0] order_mem [MAX_DETS];

   logic [cabs_pkg::THR_BITS-1:0] thr_ff;
   logic [CW-1:0] cnt_ff;
   logic ovf_ff;
   logic accept;
   det_type req_det;

   // read pipeline
   logic s1_v_ff, s2_v_ff;
   cabs_pkg::op_type s1_op_ff, s2_op_ff;
   logic [IW-1:0] s1_idx_ff, s2_idx_ff, ord_q_ff, det_addr;
   det_type det_q_ff;

   // sort
   logic [S-1:0] piv_score_ff;
   logic [IW-1:0] piv_idx_ff;
   logic [CW-1:0] rank_ff;

   // suppression
   det_type a_ff;
   logic [IN-1:0] area_a_ff;
   logic v3_ff, v4_ff, v5_ff, v6_ff;
   logic m3_ff, m4_ff, m5_ff, m6_ff;
   logic [IW-1:0] i3_ff, i4_ff, i5_ff, i6_ff;
   logic [DW-1:0] dx_ff, dy_ff;
   logic [2*C-1:0] whb_ff;
   logic [IN-1:0] inter4_ff, inter5_ff, lhs_ff, areab4_ff;
   logic [UN-1:0] uni_ff;
   logic [RW-1:0] rhs_ff;
   logic exceed;
   logic [MAX_DETS-1:0] keep_ff;
   logic [CW-1:0] kept_ff, emit_cnt_ff;

   // response register
   det_type out_ff;
   logic out_v_ff, out_none_ff, out_ovf_ff, out_end_ff;
   logic [CW-1:0] out_cnt_ff;
   logic emit_load;

   assign accept = req_ch.valid && cmd.load_en;
   assign req_ch.ready = cmd.load_en;
   assign req_det = '{cx: req_ch.center_x, cy: req_ch.center_y, w: req_ch.box_width,
                      h: req_ch.box_height, score: req_ch.score, cls: req_ch.class_id,
                      batch: req_ch.batch_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cabs_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.set_clear) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept && (req_ch.score != '0)) begin
         if (cnt_ff < CW'(MAX_DETS)) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_ch.score != '0) && (cnt_ff < CW'(MAX_DETS))) begin
         det_mem[cnt_ff[IW-1:0]] <= req_det;
      end
      det_q_ff <= det_mem[det_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.order_write) begin
         order_mem[rank_ff[IW-1:0]] <= piv_idx_ff;
      end
      ord_q_ff <= order_mem[idx];
   end

   // Sort operations address the detections directly, the others go through
   // the sorted order.
   assign det_addr = (s1_op_ff inside {cabs_pkg::OP_SORT_PIV, cabs_pkg::OP_SORT_CMP})
                     ? s1_idx_ff : ord_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
         v6_ff   <= 1'b0;
      end else begin
         s1_v_ff <= cmd.issue;
         s2_v_ff <= s1_v_ff;
         v3_ff   <= s2_v_ff && (s2_op_ff == cabs_pkg::OP_SUP_CMP);
         v4_ff   <= v3_ff;
         v5_ff   <= v4_ff;
         v6_ff   <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= cmd.op;
      s1_idx_ff <= idx;
      s2_op_ff  <= s1_op_ff;
      s2_idx_ff <= s1_idx_ff;
   end

   // Rank of the pivot: entries with a higher score, or an equal score that
   // was loaded earlier, go ahead of it.
   always_ff @(posedge clock) begin
      if (s2_v_ff && (s2_op_ff == cabs_pkg::OP_SORT_PIV)) begin
         piv_score_ff <= det_q_ff.score;
         piv_idx_ff   <= s2_idx_ff;
         rank_ff      <= '0;
      end else if (s2_v_ff && (s2_op_ff == cabs_pkg::OP_SORT_CMP)) begin
         if ((det_q_ff.score > piv_score_ff) ||
             ((det_q_ff.score == piv_score_ff) && (s2_idx_ff < piv_idx_ff))) begin
            rank_ff <= rank_ff + CW'(1);
         end
      end
   end

   // IoU pipeline: overlap, intersection, union, threshold product, compare.
   always_ff @(posedge clock) begin
      if (s2_v_ff && (s2_op_ff == cabs_pkg::OP_SUP_PIV)) begin
         a_ff <= det_q_ff;
      end
      area_a_ff <= {(2*C)'(a_ff.w) * (2*C)'(a_ff.h), 2'b00};
      dx_ff     <= overlap(a_ff.cx, a_ff.w, det_q_ff.cx, det_q_ff.w);
      dy_ff     <= overlap(a_ff.cy, a_ff.h, det_q_ff.cy, det_q_ff.h);
      whb_ff    <= det_q_ff.w * det_q_ff.h;
      m3_ff     <= (a_ff.batch == det_q_ff.batch) && (a_ff.cls == det_q_ff.cls);
      i3_ff     <= s2_idx_ff;
      inter4_ff <= dx_ff * dy_ff;
      areab4_ff <= {whb_ff, 2'b00};
      m4_ff     <= m3_ff;
      i4_ff     <= i3_ff;
      uni_ff    <= UN'(area_a_ff) + UN'(areab4_ff) - UN'(inter4_ff);
      inter5_ff <= inter4_ff;
      m5_ff     <= m4_ff;
      i5_ff     <= i4_ff;
      rhs_ff    <= thr_ff * uni_ff;
      lhs_ff    <= inter5_ff;
      m6_ff     <= m5_ff;
      i6_ff     <= i5_ff;
   end

   assign exceed = RW'({lhs_ff, 16'h0000}) > rhs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= '0;
         kept_ff <= '0;
      end else if (cmd.set_clear) begin
         keep_ff <= '0;
      end else if (cmd.keep_init) begin
         keep_ff <= '1;
         kept_ff <= cnt_ff;
      end else if (v6_ff && m6_ff && exceed && keep_ff[i6_ff]) begin
         keep_ff[i6_ff] <= 1'b0;
         kept_ff        <= kept_ff - CW'(1);
      end
   end

   assign emit_load = s2_v_ff && (s2_op_ff == cabs_pkg::OP_EMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff    <= 1'b0;
         emit_cnt_ff <= '0;
      end else begin
         if (emit_load || cmd.emit_none) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
         if (cmd.set_clear) begin
            emit_cnt_ff <= '0;
         end else if (emit_load) begin
            emit_cnt_ff <= emit_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         out_ff      <= det_q_ff;
         out_cnt_ff  <= kept_ff;
         out_none_ff <= 1'b0;
         out_ovf_ff  <= ovf_ff;
         out_end_ff  <= (emit_cnt_ff + CW'(1)) == kept_ff;
      end else if (cmd.emit_none) begin
         out_ff      <= '0;
         out_cnt_ff  <= '0;
         out_none_ff <= 1'b1;
         out_ovf_ff  <= ovf_ff;
         out_end_ff  <= 1'b1;
      end
   end

   assign rsp_ch.valid        = out_v_ff;
   assign rsp_ch.out_center_x = out_ff.cx;
   assign rsp_ch.out_center_y = out_ff.cy;
   assign rsp_ch.out_width    = out_ff.w;
   assign rsp_ch.out_height   = out_ff.h;
   assign rsp_ch.out_score    = out_ff.score;
   assign rsp_ch.out_class    = out_ff.cls;
   assign rsp_ch.out_batch    = out_ff.batch;
   assign rsp_ch.kept_count   = out_cnt_ff;
   assign rsp_ch.none_kept    = out_none_ff;
   assign rsp_ch.overflowed   = out_ovf_ff;
   assign rsp_ch.end_of_set   = out_end_ff;

   assign n                = cnt_ff;
   assign status.busy      = s1_v_ff || s2_v_ff || v3_ff || v4_ff || v5_ff || v6_ff;
   assign status.keep_bit  = keep_ff[idx];
   assign status.out_free  = !out_v_ff || rsp_ch.ready;
   assign status.none_kept = (kept_ff == '0);
   assign status.last_seen = accept && req_ch.last;

endmodule

>>> hdl/class_aware_box_suppression.sv
// ----------------------------------------------------------------------------
// class_aware_box_suppression: greedy non-maximum suppression per class
// Loads a set of detections, sorts them by score and drops overlapping
// boxes of the same batch and class; the survivors leave in score order.
// ----------------------------------------------------------------------------
// Usage. Detections arrive one word per handshake on req_ch; a word with a
// zero score is not stored, and words beyond MAX_DETS are dropped and flag
// overflow. The word with last set closes the set; the block then drops
// req_ch.ready until the set is done. After the last word, the rank sort
// makes one compare per cycle through the detection memory read port, and
// suppression one pair per cycle through the IoU pipeline against each later
// box for every kept pivot; emission reads the kept boxes in sorted order.
// Each pivot and each kept box waits for the pipeline to drain.
// Results leave on rsp_ch, one word per kept box, with end_of_set on the
// last; a set with no survivor gives a single word with none_kept set.
// A stalled receiver holds the response register and pauses emission; the
// next set may start loading while the final word still waits.
// Reset is synchronous and clears the set; iou_threshold returns to 29491
// and is written through csr_we/csr_wdata. The user must write it only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module class_aware_box_suppression #(
   parameter int MAX_DETS   = cabs_pkg::MAX_DETS_DEF,
   parameter int COORD_BITS = cabs_pkg::COORD_BITS_DEF,
   parameter int SCORE_BITS = cabs_pkg::SCORE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   cabs_req_if.sink                      req_ch,
   cabs_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic [cabs_pkg::THR_BITS-1:0] csr_wdata
);

   localparam int IW = $clog2(MAX_DETS);
   localparam int CW = $clog2(MAX_DETS + 1);

   // Commands and status are the only link between sequencer and datapath.
   cabs_pkg::cmd_type    cmd;
   cabs_pkg::status_type status;
   logic [IW-1:0]        idx;
   logic [CW-1:0]        n;

   cabs_ctrl #(
      .MAX_DETS(MAX_DETS)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .n     (n),
      .cmd   (cmd),
      .idx   (idx)
   );

   cabs_datapath #(
      .MAX_DETS  (MAX_DETS),
      .COORD_BITS(COORD_BITS),
      .SCORE_BITS(SCORE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .idx      (idx),
      .status   (status),
      .n        (n),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

endmodule
